>>> design/tlphm_pkg.sv
package tlphm_pkg;

    // Address split and pool size.
    localparam int PAGE_SHIFT      = 12;
    localparam int LEAF_INDEX_BITS = 10;
    localparam int ADDRESS_BITS    = 32;
    localparam int LEAF_BLOCKS     = 16;
    localparam int HANDLE_BITS     = 32;

    // Stream field widths.
    localparam int FIELD_W = 32;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;

    // Derived geometry.
    localparam int PAGE_W     = ADDRESS_BITS - PAGE_SHIFT;
    localparam int DIR_BITS   = PAGE_W - LEAF_INDEX_BITS;
    localparam int DIR_DEPTH  = 1 << DIR_BITS;
    localparam int LEAF_DEPTH = 1 << LEAF_INDEX_BITS;
    localparam int BLK_W      = (LEAF_BLOCKS > 1) ? $clog2(LEAF_BLOCKS) : 1;
    localparam int FREE_W     = $clog2(LEAF_BLOCKS + 1);
    localparam int LEAF_TOTAL = LEAF_BLOCKS * LEAF_DEPTH;
    localparam int LEAF_AW    = BLK_W + LEAF_INDEX_BITS;
    localparam int CNT_W      = FIELD_W - PAGE_SHIFT;
    localparam int CLR_DEPTH  = (LEAF_TOTAL > DIR_DEPTH) ? LEAF_TOTAL : DIR_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    // Command queue between front and back.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // Stream packing.
    localparam int IN_FIELDS_W  = 3 * FIELD_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = HANDLE_BITS + ST_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Operation codes on the input stream.
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_MAPPED = 2'd1,
        ST_NODIR  = 2'd2,
        ST_POOL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_NOP,
        K_LOOKUP,
        K_SET,
        K_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [PAGE_W-1:0]      page;
        logic [CNT_W-1:0]       count;
        logic [HANDLE_BITS-1:0] handle;
    } t_cmd;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        t_status                status;
    } t_result;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

>>> design/tlphm_front.sv
module tlphm_front
    import tlphm_pkg::*;
(
    input  logic                  i_tvalid,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic [OP_W-1:0]       i_tuser,
    output logic                  o_tready,
    input  t_back_stat            i_bstat,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [FIELD_W-1:0] addr;
    logic [FIELD_W-1:0] handle;
    logic [FIELD_W-1:0] size;
    logic [CNT_W-1:0]   count;

    // Unpack the transfer.
    assign addr   = i_tdata[FIELD_W-1:0];
    assign handle = i_tdata[2*FIELD_W-1:FIELD_W];
    assign size   = i_tdata[3*FIELD_W-1:2*FIELD_W];
    assign count  = size[FIELD_W-1:PAGE_SHIFT];

    // Items are held off while the store is being cleared or the queue is full.
    assign o_tready = !i_bstat.clearing && !i_q_full;
    assign o_push   = i_tvalid && o_tready;

    // Classify the item; ranges shorter than a page and unused codes do nothing.
    always_comb begin
        o_cmd.page   = addr[ADDRESS_BITS-1:PAGE_SHIFT];
        o_cmd.count  = count;
        o_cmd.handle = handle[HANDLE_BITS-1:0];
        unique case (i_tuser)
            OP_LOOKUP: o_cmd.kind = K_LOOKUP;
            OP_SET:    o_cmd.kind = (count == '0) ? K_NOP : K_SET;
            OP_CLEAR:  o_cmd.kind = (count == '0) ? K_NOP : K_CLEAR;
            default:   o_cmd.kind = K_NOP;
        endcase
    end

endmodule

>>> design/tlphm_cmdq.sv
module tlphm_cmdq
    import tlphm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr;
    logic [CMDQ_AW:0]   r_count;

    assign o_full  = (r_count == (CMDQ_AW + 1)'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> design/tlphm_back.sv
module tlphm_back
    import tlphm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    output logic       o_q_pop,
    output t_back_stat o_bstat,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR_RD,
        S_DIR_CHK,
        S_LEAF_RD,
        S_LEAF_CHK,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [CLR_W-1:0]       r_clr_idx;
    logic [FREE_W-1:0]      r_next_free;
    t_kind                  r_kind;
    logic [PAGE_W-1:0]      r_page;
    logic [CNT_W-1:0]       r_cnt;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [BLK_W-1:0]       r_blk;
    t_status                r_status;
    logic [HANDLE_BITS-1:0] r_result;
    logic                   r_out_valid;
    t_result                r_out;

    // Directory holds a valid bit over the block number; leaf store holds handles.
    logic [BLK_W:0]         dir_mem [DIR_DEPTH];
    logic [HANDLE_BITS-1:0] leaf_mem [LEAF_TOTAL];
    logic [BLK_W:0]         r_dir_q;
    logic [HANDLE_BITS-1:0] r_leaf_q;

    logic                       dir_valid;
    logic [BLK_W-1:0]           dir_blk;
    logic                       pool_empty;
    logic                       alloc;
    logic                       page_last;
    logic [DIR_BITS-1:0]        page_dir;
    logic [LEAF_INDEX_BITS-1:0] slot;
    logic                       dir_we;
    logic [DIR_BITS-1:0]        dir_wa;
    logic [BLK_W:0]             dir_wd;
    logic                       leaf_we;
    logic [LEAF_AW-1:0]         leaf_wa;
    logic [HANDLE_BITS-1:0]     leaf_wd;

    function automatic t_status st_max(input t_status a, input t_status b);
        st_max = (a > b) ? a : b;
    endfunction

    assign dir_valid  = r_dir_q[BLK_W];
    assign dir_blk    = r_dir_q[BLK_W-1:0];
    assign pool_empty = (r_next_free >= FREE_W'(LEAF_BLOCKS));
    assign page_dir   = r_page[PAGE_W-1:LEAF_INDEX_BITS];
    assign slot       = r_page[LEAF_INDEX_BITS-1:0];
    assign page_last  = (r_cnt == CNT_W'(1));
    assign alloc      = (r_state == S_DIR_CHK) && (r_kind == K_SET) && !dir_valid
                        && !pool_empty;

    assign o_q_pop          = (r_state == S_IDLE) && i_q_valid;
    assign o_bstat.clearing = (r_state == S_CLEAR);
    assign o_res_valid      = r_out_valid;
    assign o_res            = r_out;

    // Write ports of both stores: clearing sweep, allocation, set and clear.
    always_comb begin
        dir_we  = 1'b0;
        dir_wa  = page_dir;
        dir_wd  = {1'b1, r_next_free[BLK_W-1:0]};
        leaf_we = 1'b0;
        leaf_wa = {r_blk, slot};
        leaf_wd = r_handle;
        if (r_state == S_CLEAR) begin
            dir_we  = ({1'b0, r_clr_idx} < (CLR_W + 1)'(DIR_DEPTH));
            dir_wa  = r_clr_idx[DIR_BITS-1:0];
            dir_wd  = '0;
            leaf_we = ({1'b0, r_clr_idx} < (CLR_W + 1)'(LEAF_TOTAL));
            leaf_wa = r_clr_idx[LEAF_AW-1:0];
            leaf_wd = '0;
        end else if (alloc) begin
            dir_we = 1'b1;
        end else if ((r_state == S_DIR_CHK) && (r_kind == K_CLEAR) && dir_valid) begin
            leaf_we = 1'b1;
            leaf_wa = {dir_blk, slot};
            leaf_wd = '0;
        end else if ((r_state == S_LEAF_CHK) && (r_kind == K_SET)) begin
            leaf_we = 1'b1;
        end
    end

    // Directory memory with registered read.
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_wa] <= dir_wd;
        end
        r_dir_q <= dir_mem[page_dir];
    end

    // Leaf memory with registered read.
    always_ff @(posedge i_clk) begin
        if (leaf_we) begin
            leaf_mem[leaf_wa] <= leaf_wd;
        end
        r_leaf_q <= leaf_mem[{r_blk, slot}];
    end

    // Sequencer: one page per pass through the directory and leaf reads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_next_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A waiting result leaves on its transfer unless the next one replaces it.
            if (r_out_valid && i_res_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == CLR_W'(CLR_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_kind   <= i_cmd.kind;
                        r_page   <= i_cmd.page;
                        r_cnt    <= i_cmd.count;
                        r_handle <= i_cmd.handle;
                        r_status <= ST_OK;
                        r_result <= '0;
                        r_state  <= (i_cmd.kind == K_NOP) ? S_DONE : S_DIR_RD;
                    end
                end
                S_DIR_RD: begin
                    r_state <= S_DIR_CHK;
                end
                S_DIR_CHK: begin
                    unique case (r_kind)
                        K_LOOKUP: begin
                            r_blk   <= dir_blk;
                            r_state <= dir_valid ? S_LEAF_RD : S_DONE;
                        end
                        K_SET: begin
                            if (dir_valid) begin
                                r_blk   <= dir_blk;
                                r_state <= S_LEAF_RD;
                            end else if (pool_empty) begin
                                r_status <= st_max(r_status, ST_POOL);
                                r_page   <= r_page + 1'b1;
                                r_cnt    <= r_cnt - 1'b1;
                                r_state  <= page_last ? S_DONE : S_DIR_RD;
                            end else begin
                                r_blk       <= r_next_free[BLK_W-1:0];
                                r_next_free <= r_next_free + 1'b1;
                                r_state     <= S_LEAF_RD;
                            end
                        end
                        K_CLEAR: begin
                            if (!dir_valid) begin
                                r_status <= st_max(r_status, ST_NODIR);
                            end
                            r_page  <= r_page + 1'b1;
                            r_cnt   <= r_cnt - 1'b1;
                            r_state <= page_last ? S_DONE : S_DIR_RD;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_LEAF_RD: begin
                    r_state <= S_LEAF_CHK;
                end
                S_LEAF_CHK: begin
                    if (r_kind == K_LOOKUP) begin
                        r_result <= r_leaf_q;
                        r_state  <= S_DONE;
                    end else begin
                        if (r_leaf_q != '0) begin
                            r_status <= st_max(r_status, ST_MAPPED);
                        end
                        r_page  <= r_page + 1'b1;
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= page_last ? S_DONE : S_DIR_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_res_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out.handle  <= r_result;
                        r_out.status  <= r_status;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Reset always starts the clearing sweep.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> r_state == S_CLEAR)
        else $error("sequencer did not enter the clearing sweep after reset");

    // No command leaves the queue before the stores are clean.
    a_no_pop_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_q_pop)
        else $error("command taken during clearing sweep");

    // Each allocation consumes exactly one pool block.
    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc |=> r_next_free == $past(r_next_free) + FREE_W'(1))
        else $error("pool counter did not advance on allocation");

    // Only lookups return a handle, and lookups never raise a status.
    a_lookup_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_kind == K_LOOKUP) |-> r_status == ST_OK)
        else $error("lookup raised a status");

    a_range_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_kind != K_LOOKUP) |-> r_result == '0)
        else $error("non-lookup result carries a handle");

endmodule

>>> design/two_level_page_handle_map.sv
// A lookup reads its directory entry and then its leaf entry, skipping the leaf read
// if the directory entry is missing; a range shorter than a page or an unused op does
// no reads. A set range reads the directory and the leaf for each page (the directory
// only for a page skipped on an empty pool); a clear range reads the directory only.
// The back sequencer handles one item at a time and takes the next from the queue only when idle.
// Reset: a clearing sweep zeroes both stores; s_axis_tready stays low.
module two_level_page_handle_map
    import tlphm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // byte_address [31:0], handle_in [63:32], size_bytes [95:64]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op [1:0]
    input  logic [OP_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // handle_out [31:0], status [33:32], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_back_stat bstat;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    t_cmd       front_cmd;
    t_cmd       q_cmd;
    t_result    res;

    tlphm_front u_front (
        .i_tvalid (s_axis_tvalid),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .o_tready (s_axis_tready),
        .i_bstat  (bstat),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    tlphm_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tlphm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_q_pop     (q_pop),
        .o_bstat     (bstat),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    // Pack the result transfer.
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, res.status, res.handle};

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tlphm_pkg::*;

    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_ITEMS     = 1500;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int BURST_ITEMS      = 16;
    localparam int SETTLE_CYCLES    = 32;

    // The fourth op code has no meaning in the block and must act as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Shadow of the page map: directory, leaf blocks and the never-freed pool.
    // Each accepted request is applied here and its result queued in order.
    class handle_map_shadow;
        bit                   dir_valid [DIR_DEPTH];
        bit [BLK_W-1:0]       dir_block [DIR_DEPTH];
        bit [HANDLE_BITS-1:0] leaf_mem  [LEAF_TOTAL];
        int unsigned          blocks_taken;
        int unsigned          mismatch_count;
        t_result              due_results [$];

        function int unsigned pending();
            return due_results.size();
        endfunction

        function int unsigned leaf_index(int unsigned dir_idx, logic [PAGE_W-1:0] page);
            return int'(dir_block[dir_idx]) * LEAF_DEPTH + int'(page[LEAF_INDEX_BITS-1:0]);
        endfunction

        // Set one page, taking a leaf block on first use of its directory entry.
        function t_status write_page(logic [PAGE_W-1:0] page,
                                     logic [HANDLE_BITS-1:0] handle);
            int unsigned dir_idx;
            int unsigned leaf_idx;
            t_status     st;
            dir_idx = page[PAGE_W-1:LEAF_INDEX_BITS];
            st = ST_OK;
            if (!dir_valid[dir_idx]) begin
                if (blocks_taken >= LEAF_BLOCKS) return ST_POOL;
                dir_valid[dir_idx] = 1'b1;
                dir_block[dir_idx] = BLK_W'(blocks_taken);
                blocks_taken++;
            end
            leaf_idx = leaf_index(dir_idx, page);
            if (leaf_mem[leaf_idx] != '0) st = ST_MAPPED;
            leaf_mem[leaf_idx] = handle;
            return st;
        endfunction

        // Clear one page; a page without a directory entry is only flagged.
        function t_status erase_page(logic [PAGE_W-1:0] page);
            int unsigned dir_idx;
            dir_idx = page[PAGE_W-1:LEAF_INDEX_BITS];
            if (!dir_valid[dir_idx]) return ST_NODIR;
            leaf_mem[leaf_index(dir_idx, page)] = '0;
            return ST_OK;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [31:0] addr,
                                   logic [31:0] handle, logic [31:0] size);
            logic [PAGE_W-1:0] base_page;
            logic [PAGE_W-1:0] page;
            logic [CNT_W-1:0]  count;
            int unsigned       dir_idx;
            t_status           st;
            t_result           res;
            base_page  = addr[ADDRESS_BITS-1:PAGE_SHIFT];
            count      = size[FIELD_W-1:PAGE_SHIFT];
            res.handle = '0;
            res.status = ST_OK;
            case (op)
                OP_LOOKUP: begin
                    dir_idx = base_page[PAGE_W-1:LEAF_INDEX_BITS];
                    if (dir_valid[dir_idx]) res.handle = leaf_mem[leaf_index(dir_idx, base_page)];
                end
                OP_SET, OP_CLEAR: begin
                    // Page numbers wrap past the top of the address space.
                    for (int unsigned i = 0; i < count; i++) begin
                        page = PAGE_W'(base_page + i);
                        st = (op == OP_SET) ? write_page(page, handle) : erase_page(page);
                        if (st > res.status) res.status = st;
                    end
                end
                default: ;
            endcase
            due_results.push_back(res);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            logic [HANDLE_BITS-1:0] got_handle;
            logic [ST_W-1:0]        got_status;
            t_result                want;
            got_handle = beat[HANDLE_BITS-1:0];
            got_status = beat[HANDLE_BITS+ST_W-1:HANDLE_BITS];
            if (due_results.size() == 0) begin
                $display("%0t: result with nothing outstanding, handle %h status %0d",
                         $time, got_handle, got_status);
                mismatch_count++;
                return;
            end
            want = due_results.pop_front();
            if (got_handle !== want.handle) begin
                $display("%0t: handle mismatch, expected %h, got %h",
                         $time, want.handle, got_handle);
                mismatch_count++;
            end
            if (got_status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got_status);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // byte_address [31:0], handle_in [63:32], size_bytes [95:64]
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // op [1:0]
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // handle_out [31:0], status [33:32], zero fill above
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    handle_map_shadow shadow_map;
    int unsigned      items_sent  = 0;
    bit               idle_on     = 1'b0;
    bit               hold_output = 1'b0;

    two_level_page_handle_map i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Record every transfer on both sides as it completes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                shadow_map.note_request(s_axis_tuser, s_axis_tdata[31:0],
                                        s_axis_tdata[63:32], s_axis_tdata[95:64]);
            end
            if (m_axis_tvalid && m_axis_tready) shadow_map.check_result(m_axis_tdata);
        end
    end

    // Mostly no gap, some short ones and an occasional long one.
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Addresses cluster on a few directory entries so that pages get reused.
    function automatic logic [31:0] pick_address();
        logic [DIR_BITS-1:0]        dir;
        logic [LEAF_INDEX_BITS-1:0] slot;
        logic [PAGE_SHIFT-1:0]      offset;
        int unsigned                roll;
        roll   = $urandom_range(0, 19);
        offset = PAGE_SHIFT'($urandom());
        if (roll == 0) return $urandom();
        if (roll < 3) dir = DIR_BITS'(DIR_DEPTH - 1 - $urandom_range(0, 1));
        else dir = DIR_BITS'($urandom_range(0, 19));
        if (roll < 7) slot = LEAF_INDEX_BITS'(LEAF_DEPTH - 1 - $urandom_range(0, 7));
        else slot = LEAF_INDEX_BITS'($urandom_range(0, 31));
        return {dir, slot, offset};
    endfunction

    // Ranges are kept short so that each one costs few cycles.
    function automatic logic [31:0] pick_size();
        logic [31:0]           pages;
        logic [PAGE_SHIFT-1:0] tail;
        int unsigned           roll;
        roll = $urandom_range(0, 19);
        tail = PAGE_SHIFT'($urandom());
        if (roll == 0) pages = 0;
        else if (roll == 1) pages = $urandom_range(17, 64);
        else pages = $urandom_range(1, 6);
        return {pages[FIELD_W-PAGE_SHIFT-1:0], tail};
    endfunction

    function automatic logic [31:0] pick_handle();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom();
    endfunction

    // Offer one request and hold it until the transfer completes.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [31:0] addr,
                                input logic [31:0] handle, input logic [31:0] size);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {size, handle, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        gap = idle_length();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every outstanding result has arrived.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (shadow_map.pending() != 0);
    endtask

    task automatic run_directed();
        // Nothing mapped yet.
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_CLEAR,  32'h0000_0000, 32'h0000_0000, 32'h0000_1000);
        // First set takes a leaf block, then a partial page range does nothing.
        send_request(OP_SET,    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_1FFF);
        send_request(OP_LOOKUP, 32'h0000_0FFF, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_SET,    32'h0000_0000, 32'h1111_1111, 32'h0000_0FFF);
        // Overwrite a mapped page, then store a zero handle over one.
        send_request(OP_SET,    32'h0000_0000, 32'hA5A5_A5A5, 32'h0000_2000);
        send_request(OP_SET,    32'h0000_1000, 32'h0000_0000, 32'h0000_1000);
        send_request(OP_LOOKUP, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000);
        // A range that runs off the top of the address space into page zero.
        send_request(OP_SET,    32'hFFFF_E000, 32'h5A5A_5A5A, 32'h0000_4000);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_CLEAR,  32'hFFFF_F000, 32'h0000_0000, 32'h0000_2000);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        // One full leaf block, then a clear that reaches an unused directory entry.
        send_request(OP_SET,    32'h0040_0000, 32'h0000_0001, 32'h0040_0000);
        send_request(OP_CLEAR,  32'h0040_0000, 32'h0000_0000, 32'h0080_0000);
        // Sweep through enough directory entries to use up the pool.
        send_request(OP_SET,    32'h00BF_F000, 32'h0000_0000, 32'h0300_2000);
        send_request(OP_LOOKUP, 32'h00F0_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_SET,    32'h00F0_0000, 32'h0000_0007, 32'h0000_1000);
        send_request(OP_SET,    32'h0040_0000, 32'h0000_0007, 32'h0000_3000);
        // Mapped page and exhausted pool in one range; the larger code wins.
        send_request(OP_SET,    32'h03BF_F000, 32'h0000_0009, 32'h0000_1000);
        send_request(OP_SET,    32'h03BF_F000, 32'h0000_000A, 32'h0000_2000);
        send_request(OP_CLEAR,  32'h03BF_F000, 32'h0000_0000, 32'h0000_2000);
        send_request(OP_LOOKUP, 32'h0040_2000, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_CLEAR,  32'h0000_0000, 32'h0000_0000, 32'h0000_0FFF);
    endtask

    task automatic run_random_traffic();
        logic [31:0]     addr;
        logic [31:0]     size;
        logic [31:0]     handle;
        logic [OP_W-1:0] op;
        int unsigned     start;
        int unsigned     pages;
        int unsigned     roll;
        bit              hold_done;
        bit              pause_done;
        start      = items_sent;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        while (items_sent - start < RANDOM_ITEMS) begin
            // One stretch in four runs with no gaps on either side.
            idle_on = ((items_sent / 100) % 4) != 3;
            if (!hold_done && items_sent - start >= 400) begin
                // Output held off while requests keep coming, so the input backs up.
                hold_done   = 1'b1;
                idle_on     = 1'b0;
                hold_output = 1'b1;
                repeat (BURST_ITEMS) send_request(OP_SET, pick_address(), pick_handle(), pick_size());
            end
            if (!pause_done && items_sent - start >= 900) begin
                pause_done = 1'b1;
                drain_results();
            end
            addr   = pick_address();
            size   = pick_size();
            handle = pick_handle();
            pages  = size >> PAGE_SHIFT;
            roll   = $urandom_range(0, 9);
            if (roll < 5) begin
                // Map a range, read a page of it back, and sometimes clear and reread.
                send_request(OP_SET, addr, handle, size);
                send_request(OP_LOOKUP, addr + ($urandom_range(0, pages) << PAGE_SHIFT),
                             pick_handle(), $urandom());
                if ($urandom_range(0, 1) == 1) begin
                    send_request(OP_CLEAR, addr, pick_handle(), pick_size());
                    send_request(OP_LOOKUP, addr, pick_handle(), $urandom());
                end
            end else begin
                roll = $urandom_range(0, 19);
                if (roll < 6) op = OP_SET;
                else if (roll < 10) op = OP_CLEAR;
                else if (roll < 19) op = OP_LOOKUP;
                else op = OP_UNUSED;
                if (op == OP_LOOKUP || op == OP_UNUSED) size = $urandom();
                send_request(op, addr, handle, size);
            end
        end
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        int unsigned stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_output) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end else begin
                stall = idle_length();
                if (stall == 0) begin
                    m_axis_tready <= 1'b1;
                    @(posedge i_clk);
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("two_level_page_handle_map verification failed");
        $finish;
    end

    // Main sequence: reset, directed cases, random traffic, final drain.
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= '0;
        s_axis_tdata  <= '0;
        shadow_map = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;
        run_directed();
        drain_results();
        run_random_traffic();
        idle_on = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (shadow_map.mismatch_count == 0) begin
            $display("two_level_page_handle_map verification clean");
        end else begin
            $display("two_level_page_handle_map verification failed");
        end
        $finish;
    end

endmodule

>>> two_level_page_handle_map.f
design/tlphm_pkg.sv
design/tlphm_front.sv
design/tlphm_cmdq.sv
design/tlphm_back.sv
design/two_level_page_handle_map.sv
tb/sv/testbench.sv
